### rtl/deq_pkg.sv
// shared constants and types for the double-ended queue core
`default_nettype none

package deq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int FUNC_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int FILL_W     = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 80;

    localparam logic [FUNC_W-1:0] F_PUSH_FRONT   = 3'd0;
    localparam logic [FUNC_W-1:0] F_PUSH_BACK    = 3'd1;
    localparam logic [FUNC_W-1:0] F_REMOVE_FRONT = 3'd2;
    localparam logic [FUNC_W-1:0] F_REMOVE_BACK  = 3'd3;
    localparam logic [FUNC_W-1:0] F_REVERSE      = 3'd4;
    localparam logic [FUNC_W-1:0] F_STATUS       = 3'd5;

    localparam int RESULT_W = 2 * VALUE_W + FILL_W + 4;

    typedef struct packed {
        logic               op_error;
        logic               has_second;
        logic               is_full;
        logic               is_empty;
        logic [FILL_W-1:0]  fill_count;
        logic [VALUE_W-1:0] back_value;
        logic [VALUE_W-1:0] front_value;
    } t_result;

endpackage

`default_nettype wire

### rtl/double_ended_queue_core.sv
// top level of the double-ended queue core: control, end-word registers and result queue
//
// Bounded double-ended queue of DEPTH words kept in a ring ram. Each request
// (push front, push back, remove front, remove back, reverse, status) is taken in
// S_IDLE, where the end pointers and count are updated and a ram write or read is
// started; in S_FIN the read word of the new end is collected and the result is
// queued. The words at both ends are kept in registers, so at most one ram access
// is made per request. Reverse flips a direction flag only. A push when full or a
// removal when empty is ignored and reported through op_error. A two-entry
// result queue lets the next request be taken while a result still waits.
`default_nettype none

module double_ended_queue_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // item_value
    input  wire logic [deq_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // func
    input  wire logic [deq_pkg::FUNC_W-1:0]      i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // front_value, back_value, fill_count, is_empty, is_full, has_second,
    // op_error, zero fill
    output logic      [deq_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    import deq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_FIN  = 1'b1;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    logic                  r_state;
    logic [IDX_W-1:0]      r_front, n_front;
    logic [IDX_W-1:0]      r_back, n_back;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_rev, n_rev;
    logic                  r_err, n_err;
    logic                  r_rd_low, n_rd_low;
    logic                  r_rd_high, n_rd_high;
    logic [DATA_WIDTH-1:0] r_low, n_low;
    logic [DATA_WIDTH-1:0] r_high, n_high;

    t_result               r_q0, n_q0;
    t_result               r_q1, n_q1;
    logic [1:0]            r_q_cnt, n_q_cnt;

    logic                  s_accept;
    logic [FUNC_W-1:0]     func;
    logic [DATA_WIDTH-1:0] item;
    logic                  at_high;
    logic                  empty;
    logic                  full;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [DATA_WIDTH-1:0] w_low;
    logic [DATA_WIDTH-1:0] w_high;
    logic [DATA_WIDTH-1:0] w_front;
    logic [DATA_WIDTH-1:0] w_back;
    t_result               res;
    logic                  q_push;
    logic                  q_pop;

    assign o_s_axis_tready = (r_state == S_IDLE) && (r_q_cnt != 2'd2);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign func            = i_s_axis_tuser;
    assign item            = DATA_WIDTH'(i_s_axis_tdata);
    assign empty           = (r_count == '0);
    assign full            = (r_count == CNT_FULL);
    assign at_high         = ((func == F_PUSH_FRONT) || (func == F_REMOVE_FRONT)) ? r_rev : !r_rev;

    // request decode and pointer update
    always_comb begin
        n_front   = r_front;
        n_back    = r_back;
        n_count   = r_count;
        n_rev     = r_rev;
        n_err     = r_err;
        n_rd_low  = r_rd_low;
        n_rd_high = r_rd_high;
        n_low     = r_low;
        n_high    = r_high;
        ram_we    = 1'b0;
        ram_waddr = r_front;
        ram_re    = 1'b0;
        ram_raddr = r_front;
        if (s_accept) begin
            n_err     = 1'b0;
            n_rd_low  = 1'b0;
            n_rd_high = 1'b0;
            case (func)
                F_PUSH_FRONT, F_PUSH_BACK: begin
                    if (full) begin
                        n_err = 1'b1;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + 1'b1;
                        if (empty) begin
                            n_back    = r_front;
                            ram_waddr = r_front;
                            n_low     = item;
                            n_high    = item;
                        end else if (at_high) begin
                            n_back    = idx_inc(r_back);
                            ram_waddr = idx_inc(r_back);
                            n_high    = item;
                        end else begin
                            n_front   = idx_dec(r_front);
                            ram_waddr = idx_dec(r_front);
                            n_low     = item;
                        end
                    end
                end
                F_REMOVE_FRONT, F_REMOVE_BACK: begin
                    if (empty) begin
                        n_err = 1'b1;
                    end else begin
                        n_count = r_count - 1'b1;
                        if (r_count > CNT_ONE) begin
                            if (at_high) begin
                                n_back    = idx_dec(r_back);
                                ram_raddr = idx_dec(r_back);
                            end else begin
                                n_front   = idx_inc(r_front);
                                ram_raddr = idx_inc(r_front);
                            end
                            if (r_count == CNT_TWO) begin
                                if (at_high) begin
                                    n_high = r_low;
                                end else begin
                                    n_low = r_high;
                                end
                            end else begin
                                ram_re    = 1'b1;
                                n_rd_high = at_high;
                                n_rd_low  = !at_high;
                            end
                        end
                    end
                end
                F_REVERSE: begin
                    n_rev = !r_rev;
                end
                default: begin
                end
            endcase
        end else if (r_state == S_FIN) begin
            n_rd_low  = 1'b0;
            n_rd_high = 1'b0;
            n_low     = w_low;
            n_high    = w_high;
        end
    end

    // end words with the ram read forwarded in S_FIN
    assign w_low   = r_rd_low ? ram_rdata : r_low;
    assign w_high  = r_rd_high ? ram_rdata : r_high;
    assign w_front = empty ? '0 : (r_rev ? w_high : w_low);
    assign w_back  = empty ? '0 : (r_rev ? w_low : w_high);

    always_comb begin
        res.front_value = VALUE_W'(w_front);
        res.back_value  = VALUE_W'(w_back);
        res.fill_count  = FILL_W'(r_count);
        res.is_empty    = empty;
        res.is_full     = full;
        res.has_second  = (r_count >= CNT_TWO);
        res.op_error    = r_err;
    end

    // two-entry result queue
    assign q_push = (r_state == S_FIN);
    assign q_pop  = (r_q_cnt != 2'd0) && i_m_axis_tready;

    always_comb begin
        n_q0    = r_q0;
        n_q1    = r_q1;
        n_q_cnt = r_q_cnt;
        case ({q_push, q_pop})
            2'b10: begin
                if (r_q_cnt == 2'd0) begin
                    n_q0 = res;
                end else begin
                    n_q1 = res;
                end
                n_q_cnt = r_q_cnt + 1'b1;
            end
            2'b01: begin
                n_q0    = r_q1;
                n_q_cnt = r_q_cnt - 1'b1;
            end
            2'b11: begin
                if (r_q_cnt == 2'd1) begin
                    n_q0 = res;
                end else begin
                    n_q0 = r_q1;
                    n_q1 = res;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_back    <= '0;
            r_count   <= '0;
            r_rev     <= 1'b0;
            r_err     <= 1'b0;
            r_rd_low  <= 1'b0;
            r_rd_high <= 1'b0;
            r_q_cnt   <= 2'd0;
        end else begin
            r_state   <= s_accept ? S_FIN : S_IDLE;
            r_front   <= n_front;
            r_back    <= n_back;
            r_count   <= n_count;
            r_rev     <= n_rev;
            r_err     <= n_err;
            r_rd_low  <= n_rd_low;
            r_rd_high <= n_rd_high;
            r_q_cnt   <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low  <= n_low;
        r_high <= n_high;
        r_q0   <= n_q0;
        r_q1   <= n_q1;
    end

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (item),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_axis_tvalid = (r_q_cnt != 2'd0);
    assign o_m_axis_tdata  = OUT_DATA_W'(r_q0);

endmodule

`default_nettype wire

### rtl/deq_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
